// ----- rtl/shk_pkg.sv -----
// shared constants, types and control bundles for the string key hash table
package shk_pkg;

  localparam int unsigned MAP_SLOTS      = 512;
  localparam int unsigned ENTRY_CAPACITY = 256;
  localparam int unsigned MAX_KEY_LEN    = 32;

  localparam int unsigned SLOT_W = $clog2(MAP_SLOTS);
  localparam int unsigned ENT_W  = $clog2(ENTRY_CAPACITY);
  localparam int unsigned CNT_W  = $clog2(ENTRY_CAPACITY + 1);
  localparam int unsigned LEN_W  = $clog2(MAX_KEY_LEN + 1);
  localparam int unsigned KIDX_W = $clog2(MAX_KEY_LEN);
  localparam int unsigned IDX_OUT_W = 8;

  typedef enum logic [2:0] {
    STS_FOUND    = 3'd0,
    STS_INSERTED = 3'd1,
    STS_NOTFOUND = 3'd2,
    STS_FULL     = 3'd3,
    STS_TOOLONG  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    IDX_NONE = 2'd0,
    IDX_WALK = 2'd1,
    IDX_USED = 2'd2
  } idx_sel_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_HEAD_CHK,
    S_LEN,
    S_LEN_CHK,
    S_BYTE,
    S_BYTE_CHK,
    S_NEXT,
    S_NEXT_CHK,
    S_MISS,
    S_COPY,
    S_LINK,
    S_LINK2,
    S_RESULT
  } state_e;

  typedef struct packed {
    logic     accept;
    logic     clr_step;
    logic     head_load;
    logic     next_load;
    logic     j_clr;
    logic     j_inc;
    logic     copy_wr;
    logic     link_wr;
    logic     link2_wr;
    logic     res_set;
    status_e  res_code;
    idx_sel_e res_idx;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic overlong;
    logic head_valid;
    logic len_eq;
    logic byte_eq;
    logic j_last;
    logic next_valid;
    logic full;
    logic op;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/string_key_hash_table.sv -----
// top level of the string key hash table with chained slots
//
//   channel   signals                                   direction
//   input     in_valid_i in_stall_o opcode_i            in
//             key_byte_i key_last_i
//   output    out_valid_o out_stall_i status_o          out
//             entry_index_o
//
// bytes enter in S_IDLE; after a last byte the walk runs, then S_RESULT loads the result
// the walk reads the slot head, then per chain entry the length, each compared byte and
//   the link; a match ends after its last byte, an overlong key after S_HEAD
// a miss adds S_MISS, an insert S_COPY per key byte, S_LINK and S_LINK2 more
// after reset a clearing pass over the 512 slot heads holds in_stall_o high
// a stalled result holds the block at its last step until taken
module string_key_hash_table import shk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 opcode_i,
  input  logic [7:0]           key_byte_i,
  input  logic                 key_last_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [2:0]           status_o,
  output logic [IDX_OUT_W-1:0] entry_index_o
);

  cmd_t cmd;
  sts_t sts;

  shk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .key_last_i (key_last_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  shk_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .opcode_i      (opcode_i),
    .key_byte_i    (key_byte_i),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .entry_index_o (entry_index_o)
  );

endmodule

// ----- rtl/shk_datapath.sv -----
// datapath: hash, key buffer, table memories, chain walk registers and result register
module shk_datapath import shk_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             opcode_i,
  input  logic [7:0]       key_byte_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [2:0]       status_o,
  output logic [IDX_OUT_W-1:0] entry_index_o
);

  logic [31:0]       hash_q, hash_d;
  logic [LEN_W-1:0]  in_len_q;
  logic              overlong_q;
  logic [7:0]        in_key_q [MAX_KEY_LEN];
  logic              op_q;
  logic [SLOT_W-1:0] slot_q;
  logic [SLOT_W-1:0] clr_cnt_q;
  logic [ENT_W-1:0]  walk_q;
  logic [ENT_W-1:0]  prev_q;
  logic              have_prev_q;
  logic [KIDX_W-1:0] j_q;
  logic [CNT_W-1:0]  used_q;
  logic              out_valid_q;
  status_e           status_q;
  logic [ENT_W-1:0]  index_q;
  status_e           res_code_q;
  logic [ENT_W-1:0]  res_idx_q;

  logic [ENT_W:0]    head_mem [MAP_SLOTS];
  logic [ENT_W:0]    next_mem [ENTRY_CAPACITY];
  logic [7:0]        byte_mem [ENTRY_CAPACITY * MAX_KEY_LEN];
  logic [LEN_W-1:0]  len_mem  [ENTRY_CAPACITY];

  logic [ENT_W:0]    head_rd_q;
  logic [ENT_W:0]    next_rd_q;
  logic [7:0]        byte_rd_q;
  logic [LEN_W-1:0]  len_rd_q;

  logic [ENT_W-1:0]  used_idx;
  logic [31:0]       byte_ext;

  assign used_idx = used_q[ENT_W-1:0];
  assign byte_ext = {{24{key_byte_i[7]}}, key_byte_i};
  assign hash_d   = hash_q + ((hash_q << 3) ^ byte_ext);

  // incoming key and hash
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q     <= '0;
      in_len_q   <= '0;
      overlong_q <= 1'b0;
    end else if (cmd_i.accept) begin
      hash_q <= hash_d;
      if (in_len_q < LEN_W'(MAX_KEY_LEN)) begin
        in_len_q <= in_len_q + LEN_W'(1);
      end else begin
        overlong_q <= 1'b1;
      end
    end else if (cmd_i.out_load) begin
      hash_q     <= '0;
      in_len_q   <= '0;
      overlong_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= opcode_i;
      slot_q <= hash_d[SLOT_W-1:0];
      if (in_len_q < LEN_W'(MAX_KEY_LEN)) begin
        in_key_q[in_len_q[KIDX_W-1:0]] <= key_byte_i;
      end
    end
  end

  // chain walk registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q   <= '0;
      used_q      <= '0;
      have_prev_q <= 1'b0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + SLOT_W'(1);
      end
      if (cmd_i.link2_wr) begin
        used_q <= used_q + CNT_W'(1);
      end
      if (cmd_i.head_load) begin
        have_prev_q <= 1'b0;
      end else if (cmd_i.next_load) begin
        have_prev_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.head_load) begin
      walk_q <= head_rd_q[ENT_W-1:0];
    end else if (cmd_i.next_load) begin
      walk_q <= next_rd_q[ENT_W-1:0];
      prev_q <= walk_q;
    end
    if (cmd_i.j_clr) begin
      j_q <= '0;
    end else if (cmd_i.j_inc) begin
      j_q <= j_q + KIDX_W'(1);
    end
  end

  // table memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      head_mem[clr_cnt_q] <= '0;
    end else if (cmd_i.link2_wr && !have_prev_q) begin
      head_mem[slot_q] <= {1'b1, used_idx};
    end
    head_rd_q <= head_mem[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_wr) begin
      next_mem[used_idx] <= '0;
    end else if (cmd_i.link2_wr && have_prev_q) begin
      next_mem[prev_q] <= {1'b1, used_idx};
    end
    next_rd_q <= next_mem[walk_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_wr) begin
      byte_mem[{used_idx, j_q}] <= in_key_q[j_q];
    end
    byte_rd_q <= byte_mem[{walk_q, j_q}];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.link_wr) begin
      len_mem[used_idx] <= in_len_q;
    end
    len_rd_q <= len_mem[walk_q];
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // pending result, moved to the output register on load
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_code_q <= cmd_i.res_code;
      case (cmd_i.res_idx)
        IDX_WALK: res_idx_q <= walk_q;
        IDX_USED: res_idx_q <= used_idx;
        default:  res_idx_q <= '0;
      endcase
    end
    if (cmd_i.out_load) begin
      status_q <= res_code_q;
      index_q  <= res_idx_q;
    end
  end

  assign sts_o.clr_last   = &clr_cnt_q;
  assign sts_o.overlong   = overlong_q;
  assign sts_o.head_valid = head_rd_q[ENT_W];
  assign sts_o.len_eq     = (len_rd_q == in_len_q);
  assign sts_o.byte_eq    = (byte_rd_q == in_key_q[j_q]);
  assign sts_o.j_last     = ((LEN_W'(j_q) + LEN_W'(1)) == in_len_q);
  assign sts_o.next_valid = next_rd_q[ENT_W];
  assign sts_o.full       = (used_q >= CNT_W'(ENTRY_CAPACITY));
  assign sts_o.op         = op_q;
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_index_o = IDX_OUT_W'(index_q);

endmodule

// ----- rtl/shk_ctrl.sv -----
// controller: slot clear sweep, chain walk, key compare and insert sequencing
module shk_ctrl import shk_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic key_last_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o
);

  state_e state_q, state_d;
  logic   accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (accept && key_last_i) state_d = S_HEAD;
      end
      S_HEAD: begin
        state_d = sts_i.overlong ? S_RESULT : S_HEAD_CHK;
      end
      S_HEAD_CHK: begin
        state_d = sts_i.head_valid ? S_LEN : S_MISS;
      end
      S_LEN: begin
        state_d = S_LEN_CHK;
      end
      S_LEN_CHK: begin
        state_d = sts_i.len_eq ? S_BYTE : S_NEXT;
      end
      S_BYTE: begin
        state_d = S_BYTE_CHK;
      end
      S_BYTE_CHK: begin
        if (!sts_i.byte_eq) state_d = S_NEXT;
        else if (sts_i.j_last) state_d = S_RESULT;
        else state_d = S_BYTE;
      end
      S_NEXT: begin
        state_d = S_NEXT_CHK;
      end
      S_NEXT_CHK: begin
        state_d = sts_i.next_valid ? S_LEN : S_MISS;
      end
      S_MISS: begin
        state_d = (!sts_i.op || sts_i.full) ? S_RESULT : S_COPY;
      end
      S_COPY: begin
        if (sts_i.j_last) state_d = S_LINK;
      end
      S_LINK: begin
        state_d = S_LINK2;
      end
      S_LINK2: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.res_code = STS_FOUND;
    cmd_o.res_idx  = IDX_NONE;
    case (state_q)
      S_CLEAR: cmd_o.clr_step = 1'b1;
      S_IDLE:  cmd_o.accept = accept;
      S_HEAD: begin
        if (sts_i.overlong) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = STS_TOOLONG;
        end
      end
      S_HEAD_CHK: cmd_o.head_load = 1'b1;
      S_LEN_CHK:  cmd_o.j_clr = 1'b1;
      S_BYTE_CHK: begin
        if (sts_i.byte_eq && sts_i.j_last) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = STS_FOUND;
          cmd_o.res_idx  = IDX_WALK;
        end else begin
          cmd_o.j_inc = 1'b1;
        end
      end
      // the tail becomes the link target even when the chain ends here
      S_NEXT_CHK: cmd_o.next_load = 1'b1;
      S_MISS: begin
        cmd_o.j_clr = 1'b1;
        if (!sts_i.op) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = STS_NOTFOUND;
        end else if (sts_i.full) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = STS_FULL;
        end
      end
      S_COPY: begin
        cmd_o.copy_wr = 1'b1;
        cmd_o.j_inc   = 1'b1;
      end
      S_LINK: cmd_o.link_wr = 1'b1;
      S_LINK2: begin
        cmd_o.link2_wr = 1'b1;
        cmd_o.res_set  = 1'b1;
        cmd_o.res_code = STS_INSERTED;
        cmd_o.res_idx  = IDX_USED;
      end
      S_RESULT: cmd_o.out_load = sts_i.out_free;
      default: ;
    endcase
  end

endmodule

// ----- bench/string_key_hash_table_checker.sv -----
// checker for the string key hash table: predicts and compares results
module string_key_hash_table_checker import shk_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic                 opcode_i,
  input  logic [7:0]           key_byte_i,
  input  logic                 key_last_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [2:0]           status_i,
  input  logic [IDX_OUT_W-1:0] entry_index_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    status_e                sts;
    logic [IDX_OUT_W-1:0]   idx;
  } lookup_result_t;

  lookup_result_t expected_q[$];

  logic                   head_ok [MAP_SLOTS];
  logic [ENT_W-1:0]       head_ent [MAP_SLOTS];
  logic                   link_ok [ENTRY_CAPACITY];
  logic [ENT_W-1:0]       link_ent [ENTRY_CAPACITY];
  logic [7:0]             tab_key [ENTRY_CAPACITY][MAX_KEY_LEN];
  int unsigned            tab_len [ENTRY_CAPACITY];
  int unsigned            used;
  logic [31:0]            hash;
  logic [7:0]             cur_key [MAX_KEY_LEN];
  int unsigned            cur_len;
  logic                   too_long;

  assign pending_o = expected_q.size();

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic logic same_key(input int unsigned e);
    if (tab_len[e] != cur_len) return 1'b0;
    for (int i = 0; i < cur_len; i++)
      if (tab_key[e][i] != cur_key[i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic hash_request(input logic op, input logic [7:0] b, input logic last);
    logic [31:0]    ext;
    int unsigned    slot, walk, prev, steps;
    logic           have_walk, have_prev, found;
    lookup_result_t r;
    ext = {{24{b[7]}}, b};
    hash = hash + ((hash << 3) ^ ext);
    if (cur_len < MAX_KEY_LEN) begin
      cur_key[cur_len] = b;
      cur_len++;
    end else begin
      too_long = 1'b1;
    end
    if (!last) return;
    r.idx = '0;
    if (too_long) begin
      r.sts = STS_TOOLONG;
    end else begin
      slot = hash % MAP_SLOTS;
      have_walk = head_ok[slot];
      walk = head_ent[slot];
      have_prev = 1'b0;
      found = 1'b0;
      prev = 0;
      for (steps = 0; have_walk && steps < ENTRY_CAPACITY; steps++) begin
        if (same_key(walk)) begin
          found = 1'b1;
          break;
        end
        prev = walk;
        have_prev = 1'b1;
        have_walk = link_ok[walk];
        walk = link_ent[walk];
      end
      if (found) begin
        r.sts = STS_FOUND;
        r.idx = walk[7:0];
      end else if (!op) begin
        r.sts = STS_NOTFOUND;
      end else if (used >= ENTRY_CAPACITY) begin
        r.sts = STS_FULL;
      end else begin
        for (int i = 0; i < cur_len; i++) tab_key[used][i] = cur_key[i];
        tab_len[used] = cur_len;
        link_ok[used] = 1'b0;
        if (have_prev) begin
          link_ok[prev] = 1'b1;
          link_ent[prev] = used[ENT_W-1:0];
        end else begin
          head_ok[slot] = 1'b1;
          head_ent[slot] = used[ENT_W-1:0];
        end
        r.sts = STS_INSERTED;
        r.idx = used[7:0];
        used++;
      end
    end
    hash = '0;
    cur_len = 0;
    too_long = 1'b0;
    expected_q.push_back(r);
  endtask

  initial begin
    fail_count_o = 0;
    for (int i = 0; i < MAP_SLOTS; i++) head_ok[i] = 1'b0;
    for (int i = 0; i < ENTRY_CAPACITY; i++) link_ok[i] = 1'b0;
    used = 0;
    hash = '0;
    cur_len = 0;
    too_long = 1'b0;
  end

  always @(posedge clk_i) begin
    lookup_result_t e;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report($sformatf("unexpected result status %0d index %0d", status_i,
                           entry_index_i));
        end else begin
          e = expected_q.pop_front();
          if (status_i !== e.sts)
            report($sformatf("status %0d, expected %0d", status_i, e.sts));
          if (entry_index_i !== e.idx)
            report($sformatf("entry index %0d, expected %0d", entry_index_i, e.idx));
        end
      end
      if (in_valid_i && !in_stall_i) hash_request(opcode_i, key_byte_i, key_last_i);
    end
  end

endmodule

// ----- bench/string_key_hash_table_tb.sv -----
// testbench top for the string key hash table: stimulus and verdict
module string_key_hash_table_tb import shk_pkg::*;;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 opcode_i;
  logic [7:0]           key_byte_i;
  logic                 key_last_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [2:0]           status_o;
  logic [IDX_OUT_W-1:0] entry_index_o;
  int                   fail_count;
  int                   pending;
  logic                 quiet;
  logic                 hold_off;

  typedef logic [7:0] key_t [$];
  key_t key_pool [$];

  string_key_hash_table dut (.*);

  string_key_hash_table_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .key_byte_i,
    .key_last_i, .out_valid_i(out_valid_o), .out_stall_i, .status_i(status_o),
    .entry_index_i(entry_index_o), .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20000000;
    $display("Simulation FAILED");
    $finish;
  end

  // receiver stall: random bursts, one long hold-off
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        out_stall_i <= 1'b0;
        hold_off = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 4);
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic send_byte(input logic op, input logic [7:0] b, input logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    key_byte_i <= b;
    key_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_key(input logic op, input key_t k);
    for (int i = 0; i < k.size(); i++) send_byte(op, k[i], i == k.size() - 1);
  endtask

  function automatic key_t make_key(input int len);
    key_t k;
    for (int i = 0; i < len; i++) k.push_back(8'($urandom_range(0, 255)));
    return k;
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    key_t k;
    int   pick;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    opcode_i = 1'b0;
    key_byte_i = 8'h01;
    key_last_i = 1'b0;
    quiet = 1'b0;
    hold_off = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, both operations, overlong, duplicate
    k = {8'hff};               send_key(1'b0, k);
    send_key(1'b1, k);
    send_key(1'b0, k);
    k = {8'h00};               send_key(1'b1, k);
    k = {8'h80, 8'h7f, 8'h01}; send_key(1'b1, k);
    send_key(1'b1, k);
    k = make_key(MAX_KEY_LEN); send_key(1'b1, k);
    key_pool.push_back(k);
    send_key(1'b0, k);
    k = make_key(MAX_KEY_LEN + 1); send_key(1'b1, k);
    k = {8'h55, 8'haa};        send_key(1'b0, k);
    // long receiver hold-off while inserting
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) begin
      k = make_key($urandom_range(1, 6));
      key_pool.push_back(k);
      send_key(1'b1, k);
    end
    // random: new and repeated keys with either operation, and overlong keys
    for (int n = 0; n < 40; n++) begin
      pick = $urandom_range(0, 9);
      if (n > 32) quiet = 1'b1;
      if (pick < 4 && key_pool.size() > 0) begin
        send_key(1'($urandom_range(0, 1)), key_pool[$urandom_range(0, key_pool.size() - 1)]);
      end else if (pick == 9) begin
        send_key(1'($urandom_range(0, 1)), make_key($urandom_range(MAX_KEY_LEN + 1, 40)));
      end else begin
        k = make_key(pick == 8 ? $urandom_range(1, MAX_KEY_LEN) : $urandom_range(1, 4));
        key_pool.push_back(k);
        send_key(1'($urandom_range(0, 1)), k);
      end
    end
    drain();
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/shk_pkg.sv
rtl/shk_datapath.sv
rtl/shk_ctrl.sv
rtl/string_key_hash_table.sv
bench/string_key_hash_table_checker.sv
bench/string_key_hash_table_tb.sv
